// ===== hdl/dssm_pkg.sv =====
package dssm_pkg;

   // field widths of the stream items and the register
   localparam int OP_W       = 3;
   localparam int WORD_W     = 64;
   localparam int CAP_W      = 11;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FIRST  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_SECOND = 3'd1;
   localparam logic [OP_W-1:0] OP_TOP_FIRST   = 3'd2;
   localparam logic [OP_W-1:0] OP_TOP_SECOND  = 3'd3;
   localparam logic [OP_W-1:0] OP_POP_FIRST   = 3'd4;
   localparam logic [OP_W-1:0] OP_POP_SECOND  = 3'd5;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;        // item accepted this cycle
      logic load_read;   // capture memory read data into result
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_read;  // offered item is a top that will succeed
   } ctrl_status_type;

endpackage

// ===== hdl/dssm_ram.sv =====
module dssm_ram import dssm_pkg::*; #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dssm_ctrl.sv =====
module dssm_ctrl import dssm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic            csr_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.take      = 1'b0;
      cmd.load_read = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      csr_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = status.needs_read ? ST_READ : ST_RESP;
            end
         end
         ST_READ: begin
            cmd.load_read = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/dssm_datapath.sv =====
module dssm_datapath import dssm_pkg::*; #(
   parameter int MAX_ENTRIES = 1024,
   parameter int WORD_BITS   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       op,
   input  logic [WORD_W-1:0]     push_word,
   input  logic                  csr_write,
   input  logic [CAP_W-1:0]      csr_value,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   output logic                  ok,
   output logic [WORD_W-1:0]     top_word
);

   localparam int ADDR_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CNT_W-1:0]     first_ff, first_in;
   logic [CNT_W-1:0]     second_ff, second_in;
   logic [CNT_W-1:0]     cap_ff, cap_in;
   logic                 ok_ff, ok_in;
   logic [WORD_BITS-1:0] top_ff;

   logic [CNT_W:0]       total;
   logic                 full;
   logic [CNT_W-1:0]     second_push_slot;
   logic [CNT_W-1:0]     second_top_slot;
   logic [CNT_W-1:0]     first_top_slot;
   logic [CMP_W-1:0]     cap_wide;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   // occupancy and slot arithmetic
   assign total            = {1'b0, first_ff} + {1'b0, second_ff};
   assign full             = total >= {1'b0, cap_ff};
   assign second_push_slot = cap_ff - second_ff - CNT_W'(1);
   assign second_top_slot  = cap_ff - second_ff;
   assign first_top_slot   = first_ff - CNT_W'(1);

   // clamp written capacity into 1..MAX_ENTRIES
   always_comb begin
      cap_wide = CMP_W'(csr_value);
      if (cap_wide == '0) begin
         cap_in = CNT_W'(1);
      end else if (cap_wide > CMP_W'(MAX_ENTRIES)) begin
         cap_in = CNT_W'(MAX_ENTRIES);
      end else begin
         cap_in = CNT_W'(cap_wide);
      end
   end

   // operation decode: counters, memory access, success flag
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      ok_in     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = first_ff[ADDR_W-1:0];
      rd_addr   = first_top_slot[ADDR_W-1:0];
      unique case (op)
         OP_PUSH_FIRST: begin
            if (!full) begin
               ok_in    = 1'b1;
               wr_en    = 1'b1;
               first_in = first_ff + CNT_W'(1);
            end
         end
         OP_PUSH_SECOND: begin
            wr_addr = second_push_slot[ADDR_W-1:0];
            if (!full) begin
               ok_in     = 1'b1;
               wr_en     = 1'b1;
               second_in = second_ff + CNT_W'(1);
            end
         end
         OP_TOP_FIRST: begin
            ok_in = first_ff != '0;
         end
         OP_TOP_SECOND: begin
            rd_addr = second_top_slot[ADDR_W-1:0];
            ok_in   = second_ff != '0;
         end
         OP_POP_FIRST: begin
            if (first_ff != '0) begin
               ok_in    = 1'b1;
               first_in = first_ff - CNT_W'(1);
            end
         end
         OP_POP_SECOND: begin
            if (second_ff != '0) begin
               ok_in     = 1'b1;
               second_in = second_ff - CNT_W'(1);
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign status.needs_read = ok_in && (op == OP_TOP_FIRST || op == OP_TOP_SECOND);
   assign rd_en             = cmd.take && status.needs_read;

   // control state: counters and capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
         cap_ff    <= CNT_W'(MAX_ENTRIES);
      end else if (csr_write) begin
         first_ff  <= '0;
         second_ff <= '0;
         cap_ff    <= cap_in;
      end else if (cmd.take) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         ok_ff  <= ok_in;
         top_ff <= '0;
      end else if (cmd.load_read) begin
         top_ff <= rd_data;
      end
   end

   dssm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.take && wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_word[WORD_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ok       = ok_ff;
   assign top_word = WORD_W'(top_ff);

endmodule

// ===== hdl/dual_stack_shared_memory.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  op, push_word
// rsp       out        rsp_tvalid/rsp_tready  ok, top_word
// csr       in         csr_valid/csr_ready    capacity
//
// Push, pop, failed top and unused codes go from IDLE straight to RESP; a
// successful top passes through READ between them, for the registered read of the word memory.
// A new item is taken only after the previous result has been accepted.
// Synchronous active-high reset empties both stacks and sets capacity to
// MAX_ENTRIES; the word memory is not cleared. Stalls on rsp hold the result.
module dual_stack_shared_memory import dssm_pkg::*; #(
   parameter int MAX_ENTRIES = 1024,
   parameter int WORD_BITS   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [2:0] op, [66:3] push_word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] ok, [64:1] top_word
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_W-1:0]      csr_data     // capacity
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            ok;
   logic [WORD_W-1:0] top_word;

   dssm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_ready  (csr_ready),
      .status     (status),
      .cmd        (cmd)
   );

   dssm_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .WORD_BITS   (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .op        (req_tdata[OP_W-1:0]),
      .push_word (req_tdata[OP_W+WORD_W-1:OP_W]),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .cmd       (cmd),
      .status    (status),
      .ok        (ok),
      .top_word  (top_word)
   );

   // pack result, zero-filled to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W-WORD_W-1){1'b0}}, top_word, ok};

endmodule
